// ===== rtl/first_match_delete_stream_defines.svh =====
`ifndef FIRST_MATCH_DELETE_STREAM_DEFINES_SVH
`define FIRST_MATCH_DELETE_STREAM_DEFINES_SVH

// Shared assertion macros. The asserting module must provide clk and rst_n.

// Property that must hold at every clock edge out of reset
`define FMDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define FMDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fmds_pkg.sv =====
package fmds_pkg;

  // Widths fixed by the register map and the byte stream
  localparam int BYTE_W     = 8;
  localparam int LEN_REG_W  = 5;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd2;

  typedef logic [BYTE_W-1:0] fmds_byte_t;

endpackage

// ===== rtl/first_match_delete_stream.sv =====
// Streams text bytes through with the first occurrence of the configured pattern removed.
// One text byte is taken per clock while the result side keeps up; its first result comes
// in the next cycle. A byte that leaves k results (the text_end flush, or excess bytes
// after pattern_length is cut mid-text) holds in_ready low until the rest are out, as the
// window cells shift one byte per cycle, while out_ready allows, into a single output
// register. An end byte that leaves nothing yields one result with out_byte_present low
// carrying the flags. The window is a row of MAX_PATTERN byte cells, oldest at cell 0.
// Lengths above MAX_PATTERN are clamped. Write configuration only while idle; the block
// does not check it. The window and the found flag are cleared after every text_end byte.
module first_match_delete_stream #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [fmds_pkg::BYTE_W-1:0]       in_text_byte,
  input  logic                              in_text_end,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fmds_pkg::BYTE_W-1:0]       out_byte,
  output logic                              out_byte_present,
  output logic                              out_match_found,
  output logic                              out_run_last,
  output logic                              out_stream_end,
  input  logic                              cfg_we,
  input  logic [fmds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fmds_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fmds_pkg::*;

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);

  // Configuration registers
  logic [LEN_REG_W-1:0]  len_cfg_r;
  logic [CFG_DATA_W-1:0] pat_lo_r;
  logic [CFG_DATA_W-1:0] pat_hi_r;

  // Window and transaction state
  logic [FILL_W-1:0]     fill_r;
  logic                  found_r;
  logic [FILL_W-1:0]     rem_r;
  logic                  job_found_r;
  logic                  job_last_r;

  // Output register
  logic                  out_valid_r;
  fmds_byte_t            out_byte_r;
  logic                  out_present_r;
  logic                  out_found_r;
  logic                  out_run_last_r;
  logic                  out_end_r;

  logic [MAX_PATTERN-1:0][BYTE_W-1:0] cand;
  // Per-cycle controls broadcast along the window cells
  logic                  cell_ins;
  logic                  cell_shift;
  logic [FILL_W-1:0]     len_act;
  logic [FILL_W-1:0]     w1;
  logic [FILL_W-1:0]     shift_d;
  logic [FILL_W-1:0]     n;
  logic [FILL_W-1:0]     fill_nxt;
  logic                  ge;
  logic                  window_ok;
  logic                  matched;
  logic                  found_after;
  logic                  advance;
  logic                  draining;
  logic                  accept;
  logic                  emit_acc;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r <= '0;
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_LENGTH: len_cfg_r <= cfg_data[LEN_REG_W-1:0];
        REG_PATTERN_LOW:    pat_lo_r  <= cfg_data;
        REG_PATTERN_HIGH:   pat_hi_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Active length, clamped to the window size
  always_comb begin
    if (len_cfg_r > LEN_REG_W'(MAX_PATTERN)) len_act = FILL_W'(MAX_PATTERN);
    else                                     len_act = FILL_W'(len_cfg_r);
  end

  // Handshake
  assign advance  = !out_valid_r || out_ready;
  assign draining = (rem_r != '0);
  assign in_ready = advance && !draining;
  assign accept   = in_valid && in_ready;

  // Row of window cells
  assign cell_ins   = accept;
  assign cell_shift = (accept && (n != '0)) || (advance && draining);

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    fmds_byte_t nbr;
    if (g == MAX_PATTERN - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cand[g+1];
    end
    fmds_cell #(
      .FILL_W (FILL_W),
      .INDEX  (g)
    ) u_cell (
      .clk       (clk),
      .ins       (cell_ins),
      .shift     (cell_shift),
      .fill      (fill_r),
      .ins_byte  (in_text_byte),
      .nbr_byte  (nbr),
      .cand_byte (cand[g])
    );
  end

  // Compare the last len bytes of the window with the pattern
  assign w1      = fill_r + FILL_W'(1);
  assign ge      = (w1 >= len_act);
  assign shift_d = ge ? (w1 - len_act) : '0;

  fmds_match #(
    .MAX_PATTERN (MAX_PATTERN),
    .FILL_W      (FILL_W)
  ) u_match (
    .cand    (cand),
    .shift_d (shift_d),
    .len     (len_act),
    .pat_lo  (pat_lo_r),
    .pat_hi  (pat_hi_r),
    .ok      (window_ok)
  );

  assign matched     = !found_r && ge && window_ok;
  assign found_after = found_r || matched;

  // Results owed by this byte, always the oldest n window bytes
  always_comb begin
    if (found_r)          n = FILL_W'(1);
    else if (matched)     n = shift_d;
    else if (in_text_end) n = w1;
    else if (ge)          n = shift_d + FILL_W'(1);
    else                  n = '0;
  end

  always_comb begin
    if (found_r || in_text_end || matched) fill_nxt = '0;
    else                                   fill_nxt = w1 - n;
  end

  assign emit_acc = accept && ((n != '0) || in_text_end);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      found_r     <= 1'b0;
      rem_r       <= '0;
      job_found_r <= 1'b0;
      job_last_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        fill_r      <= fill_nxt;
        found_r     <= found_after && !in_text_end;
        rem_r       <= (n != '0) ? (n - FILL_W'(1)) : '0;
        job_found_r <= found_after;
        job_last_r  <= in_text_end;
      end else if (advance && draining) begin
        rem_r <= rem_r - FILL_W'(1);
      end
      if (advance) out_valid_r <= emit_acc || draining;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance && draining) begin
      out_byte_r     <= cand[0];
      out_present_r  <= 1'b1;
      out_found_r    <= job_found_r;
      out_run_last_r <= (rem_r == FILL_W'(1));
      out_end_r      <= job_last_r && (rem_r == FILL_W'(1));
    end else if (emit_acc) begin
      out_byte_r     <= (n != '0) ? cand[0] : '0;
      out_present_r  <= (n != '0);
      out_found_r    <= found_after;
      out_run_last_r <= (n <= FILL_W'(1));
      out_end_r      <= in_text_end && (n <= FILL_W'(1));
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_byte_present = out_present_r;
  assign out_match_found  = out_found_r;
  assign out_run_last     = out_run_last_r;
  assign out_stream_end   = out_end_r;

`include "first_match_delete_stream_defines.svh"

  // Checks
  `FMDS_ASSERT(a_no_accept_in_drain, (rem_r != '0) |-> !in_ready, "byte taken during drain")
  `FMDS_ASSERT(a_found_empty_window, found_r |-> (fill_r == '0), "window kept after match")
  `FMDS_ASSERT(a_fill_in_range, fill_r < FILL_W'(MAX_PATTERN), "window fill out of range")
  `FMDS_ASSERT_NEXT(a_drain_steps, advance && (rem_r != '0), rem_r == ($past(rem_r) - FILL_W'(1)), "drain count did not step")
  `FMDS_ASSERT_NEXT(a_end_clears, accept && in_text_end, !found_r && (fill_r == '0), "state not cleared at text end")

endmodule

// ===== rtl/fmds_cell.sv =====
module fmds_cell #(
  parameter int FILL_W = 5,
  parameter int INDEX  = 0
) (
  input  logic                   clk,
  input  logic                   ins,
  input  logic                   shift,
  input  logic [FILL_W-1:0]      fill,
  input  fmds_pkg::fmds_byte_t   ins_byte,
  input  fmds_pkg::fmds_byte_t   nbr_byte,
  output fmds_pkg::fmds_byte_t   cand_byte
);
  import fmds_pkg::*;

  fmds_byte_t byte_r;
  logic       load;

  // New byte lands in the cell at the current fill position
  assign load      = ins && (fill == FILL_W'(INDEX));
  assign cand_byte = load ? ins_byte : byte_r;

  // Shift towards the oldest end, else keep the candidate byte
  always_ff @(posedge clk) begin
    byte_r <= shift ? nbr_byte : cand_byte;
  end

endmodule

// ===== rtl/fmds_match.sv =====
module fmds_match #(
  parameter int MAX_PATTERN = 16,
  parameter int FILL_W      = 5
) (
  input  logic [MAX_PATTERN-1:0][fmds_pkg::BYTE_W-1:0] cand,
  input  logic [FILL_W-1:0]                             shift_d,
  input  logic [FILL_W-1:0]                             len,
  input  logic [fmds_pkg::CFG_DATA_W-1:0]               pat_lo,
  input  logic [fmds_pkg::CFG_DATA_W-1:0]               pat_hi,
  output logic                                          ok
);
  import fmds_pkg::*;

  fmds_byte_t                 pat     [MAX_PATTERN];
  fmds_byte_t                 aligned [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]     eq;

  // Pattern bytes out of the two configuration words
  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_pat
    if (g < 8) begin : g_lo
      assign pat[g] = pat_lo[BYTE_W*g +: BYTE_W];
    end else begin : g_hi
      assign pat[g] = pat_hi[BYTE_W*(g-8) +: BYTE_W];
    end
  end

  // Window seen from the oldest byte that survives the excess pops
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      aligned[i] = '0;
      for (int j = i; j < MAX_PATTERN; j++) begin
        if (shift_d == FILL_W'(j - i)) aligned[i] = cand[j];
      end
    end
  end

  // Bytes beyond the active length always agree
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      eq[i] = (FILL_W'(i) >= len) || (aligned[i] == pat[i]);
    end
  end

  assign ok = &eq;

endmodule
